// ===== sv/zero_one_knapsack_dp_macros.svh =====
// Assertion macros for the knapsack engine checker.
`ifndef ZERO_ONE_KNAPSACK_DP_MACROS_SVH
`define ZERO_ONE_KNAPSACK_DP_MACROS_SVH

// Next-cycle implication that is switched off while reset is asserted.
`define ZOKDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("zero_one_knapsack_dp: assertion failed");

// Next-cycle implication that is also checked across reset.
`define ZOKDP_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("zero_one_knapsack_dp: assertion failed");

`endif

// ===== sv/zokdp_pkg.sv =====
// Shared widths and parameter defaults for the knapsack engine.
`default_nettype none

package zokdp_pkg;

  // Field widths fixed by the interface.
  localparam int CAP_W    = 10;
  localparam int WEIGHT_W = 10;
  localparam int VALUE_W  = 16;
  localparam int OUT_W    = 32;

  // Defaults for the top-level parameters.
  localparam int MAX_CAPACITY_DEF = 1023;
  localparam int ACC_BITS_DEF     = 32;

endpackage

`default_nettype wire

// ===== sv/zero_one_knapsack_dp.sv =====
// Knapsack engine: one sweep of the best-value row memory for every item word.
// Each item word sweeps the row entries from MAX_CAPACITY down to 1, then passes a drain state and
// returns to idle; a last item also passes a result-load state, which waits for the output slot.
// A last item's result word is registered when that result-load state finds the output slot free.
// Reset is synchronous and active low; afterwards a clearing pass zeroes every memory entry
// before the first item word is taken. Configuration writes are accepted at any time.
`default_nettype none

module zero_one_knapsack_dp #(
  parameter int MAX_CAPACITY = zokdp_pkg::MAX_CAPACITY_DEF,
  parameter int ACC_BITS     = zokdp_pkg::ACC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [zokdp_pkg::CAP_W-1:0]    cfg_wr_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [zokdp_pkg::WEIGHT_W-1:0] in_item_weight,
  input  wire logic [zokdp_pkg::VALUE_W-1:0]  in_item_value,
  input  wire logic                            in_last_item,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [zokdp_pkg::OUT_W-1:0]    out_best_value,
  output logic                                 out_saturated
);

  localparam int IDX_W = $clog2(MAX_CAPACITY + 1);
  localparam int CW    = (IDX_W > zokdp_pkg::WEIGHT_W) ? IDX_W : zokdp_pkg::WEIGHT_W;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SWEEP = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [zokdp_pkg::CAP_W-1:0]    cfg_capacity_r;
  logic [IDX_W-1:0]                clr_r;
  logic [IDX_W-1:0]                j_r;
  logic [zokdp_pkg::WEIGHT_W-1:0] weight_r;
  logic [zokdp_pkg::VALUE_W-1:0]  value_r;
  logic                            last_r;
  logic                            p_valid_r;
  logic [IDX_W-1:0]                p_j_r;
  logic                            p_take_r;
  logic                            sat_r;
  logic [ACC_BITS-1:0]             cap_val_r;
  logic                            out_valid_r;
  logic [zokdp_pkg::OUT_W-1:0]    out_best_value_r;
  logic                            out_saturated_r;

  logic                            accept;
  logic                            slot_free;
  logic                            take;
  logic [IDX_W-1:0]                base_addr;
  logic [IDX_W-1:0]                cap_idx;
  logic                            wr_en;
  logic [IDX_W-1:0]                wr_addr;
  logic [ACC_BITS-1:0]             wr_data;
  logic [ACC_BITS-1:0]             old_val;
  logic [ACC_BITS-1:0]             base_val;
  logic [ACC_BITS-1:0]             new_val;
  logic                            sat_hit;
  logic [63:0]                     cap_wide;
  logic                            out_ovf;

  assign in_ready       = (state_r == ST_IDLE);
  assign accept         = in_valid && in_ready;
  assign slot_free      = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_best_value = out_best_value_r;
  assign out_saturated  = out_saturated_r;

  // Reported capacity, held to the last entry of the row.
  always_comb begin
    if (CW'(cfg_capacity_r) > CW'(MAX_CAPACITY)) begin
      cap_idx = IDX_W'(MAX_CAPACITY);
    end else begin
      cap_idx = IDX_W'(cfg_capacity_r);
    end
  end

  // Read addresses for the entry under update and its partner j minus weight.
  always_comb begin
    take      = CW'(weight_r) <= CW'(j_r);
    base_addr = take ? IDX_W'(CW'(j_r) - CW'(weight_r)) : '0;
  end

  // Write-back mux: clearing pass, or the updated entry. The last item of a set
  // leaves zeros behind, so the row starts clean for the next set.
  always_comb begin
    wr_en   = (state_r == ST_CLEAR) || (p_valid_r && (p_take_r || last_r));
    wr_addr = (state_r == ST_CLEAR) ? clr_r : p_j_r;
    wr_data = ((state_r == ST_CLEAR) || last_r) ? '0 : new_val;
  end

  zokdp_row_mem #(
    .DEPTH (MAX_CAPACITY + 1),
    .AW    (IDX_W),
    .DW    (ACC_BITS)
  ) u_row_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (j_r),
    .rd_a_data (old_val),
    .rd_b_addr (base_addr),
    .rd_b_data (base_val)
  );

  zokdp_relax #(
    .ACC_BITS (ACC_BITS)
  ) u_relax (
    .take       (p_take_r),
    .old_val    (old_val),
    .base_val   (base_val),
    .item_value (value_r),
    .new_val    (new_val),
    .sat_hit    (sat_hit)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == IDX_W'(MAX_CAPACITY)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (j_r == IDX_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = last_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_r          <= '0;
      p_valid_r      <= 1'b0;
      sat_r          <= 1'b0;
      out_valid_r    <= 1'b0;
      cfg_capacity_r <= '0;
    end else begin
      state_r   <= state_nxt;
      p_valid_r <= (state_r == ST_SWEEP);
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + IDX_W'(1);
      end
      if (cfg_wr_en) begin
        cfg_capacity_r <= cfg_wr_data;
      end
      // Saturation is sticky over a set and cleared when its answer leaves.
      if ((state_r == ST_EMIT) && slot_free) begin
        sat_r <= 1'b0;
      end else if (p_valid_r && sat_hit) begin
        sat_r <= 1'b1;
      end
      // Result word register.
      if ((state_r == ST_EMIT) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and sweep registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      weight_r <= in_item_weight;
      value_r  <= in_item_value;
      last_r   <= in_last_item;
      j_r      <= IDX_W'(MAX_CAPACITY);
    end else if (state_r == ST_SWEEP) begin
      j_r <= j_r - IDX_W'(1);
    end
    p_j_r    <= j_r;
    p_take_r <= take;
  end

  // Capture of the reported entry as the sweep passes it; capacity zero stays zero.
  always_ff @(posedge clk) begin
    if (accept) begin
      cap_val_r <= '0;
    end else if (p_valid_r && (p_j_r == cap_idx)) begin
      cap_val_r <= new_val;
    end
  end

  // Result word: entries wider than the output clamp to all ones and flag saturation.
  always_comb begin
    cap_wide = 64'(cap_val_r);
    out_ovf  = |cap_wide[63:zokdp_pkg::OUT_W];
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_EMIT) && slot_free) begin
      out_best_value_r <= out_ovf ? '1 : cap_wide[zokdp_pkg::OUT_W-1:0];
      out_saturated_r  <= sat_r || out_ovf;
    end
  end

endmodule

`default_nettype wire

// ===== sv/zokdp_row_mem.sv =====
// Best-value row memory: one write port and two registered read ports.
`default_nettype none

module zokdp_row_mem #(
  parameter int DEPTH = zokdp_pkg::MAX_CAPACITY_DEF + 1,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = zokdp_pkg::ACC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_a_addr,
  output logic      [DW-1:0] rd_a_data,
  input  wire logic [AW-1:0] rd_b_addr,
  output logic      [DW-1:0] rd_b_data
);

  logic [DW-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // Two read ports, both registered.
  always_ff @(posedge clk) begin
    rd_a_data <= mem_q[rd_a_addr];
    rd_b_data <= mem_q[rd_b_addr];
  end

endmodule

`default_nettype wire

// ===== sv/zokdp_relax.sv =====
// Relaxation of one capacity entry: saturating add and keep the larger value.
`default_nettype none

module zokdp_relax #(
  parameter int ACC_BITS = zokdp_pkg::ACC_BITS_DEF
) (
  input  wire logic                         take,
  input  wire logic [ACC_BITS-1:0]          old_val,
  input  wire logic [ACC_BITS-1:0]          base_val,
  input  wire logic [zokdp_pkg::VALUE_W-1:0] item_value,
  output logic      [ACC_BITS-1:0]          new_val,
  output logic                              sat_hit
);

  logic [ACC_BITS:0]   sum;
  logic [ACC_BITS-1:0] cand;

  // Candidate sum, clamped to all ones on carry out.
  always_comb begin
    sum  = {1'b0, base_val} + (ACC_BITS + 1)'(item_value);
    cand = sum[ACC_BITS] ? '1 : sum[ACC_BITS-1:0];
  end

  // The entry keeps the larger of its old value and the candidate.
  always_comb begin
    sat_hit = take && sum[ACC_BITS];
    if (take && (cand > old_val)) begin
      new_val = cand;
    end else begin
      new_val = old_val;
    end
  end

endmodule

`default_nettype wire

// ===== sv/zero_one_knapsack_dp_chk.sv =====
// Port-level checker for the knapsack engine and its bind.
`default_nettype none
`include "zero_one_knapsack_dp_macros.svh"

module zero_one_knapsack_dp_chk (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            in_last_item,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [zokdp_pkg::OUT_W-1:0]    out_best_value,
  input wire logic                            out_saturated
);

  // A stalled result word holds.
  `ZOKDP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_best_value) && $stable(out_saturated))

  // Each item word is swept alone, so the input closes right after an acceptance.
  `ZOKDP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // A word that is not the last of its set produces no result.
  `ZOKDP_ASSERT_NEXT(a_no_result_mid_set, clk, rst_n, in_valid && in_ready && !in_last_item && !out_valid, !out_valid)

  // Reset leaves no result and starts the clearing pass.
  `ZOKDP_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, !rst_n, !out_valid && !in_ready)

endmodule

bind zero_one_knapsack_dp zero_one_knapsack_dp_chk u_chk (.*);

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the 0/1 knapsack best-value engine.
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_CAP     = zokdp_pkg::MAX_CAPACITY_DEF;
  localparam int ACC_W       = zokdp_pkg::ACC_BITS_DEF;
  localparam int SETTLE_WAIT = MAX_CAP + 80;
  localparam int HOLD_CYCLES = 8000;
  localparam int QUIET_LIMIT = 40000;

  typedef struct packed {
    logic [zokdp_pkg::OUT_W-1:0] best_value;
    logic                        saturated;
  } answer_t;

  // Clock, reset and block inputs, all known from time zero.
  logic                           clk;
  logic                           rst_n          = 1'b0;
  logic                           cfg_wr_en      = 1'b0;
  logic [zokdp_pkg::CAP_W-1:0]    cfg_wr_data    = '0;
  logic                           in_valid       = 1'b0;
  logic [zokdp_pkg::WEIGHT_W-1:0] in_item_weight = '0;
  logic [zokdp_pkg::VALUE_W-1:0]  in_item_value  = '0;
  logic                           in_last_item   = 1'b0;
  logic                           out_ready      = 1'b0;
  logic                           in_ready;
  logic                           out_valid;
  logic [zokdp_pkg::OUT_W-1:0]    out_best_value;
  logic                           out_saturated;

  // Predictor state: the best-value row, the overflow flag and the capacity.
  logic [ACC_W-1:0]               best_row [0:MAX_CAP];
  bit                             sat_seen;
  logic [zokdp_pkg::CAP_W-1:0]    cap_reg;
  answer_t                        answer_q [$];

  int                  mismatch_count = 0;
  int                  quiet_cycles   = 0;
  bit                  calm           = 1'b0;
  bit                  hold_kick      = 1'b0;
  int                  hold_left      = 0;

  zero_one_knapsack_dp u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_item_weight (in_item_weight),
    .in_item_value  (in_item_value),
    .in_last_item   (in_last_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_best_value (out_best_value),
    .out_saturated  (out_saturated)
  );

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Empty the row and the overflow flag, as at reset and after every answer.
  function automatic void clear_row();
    foreach (best_row[i]) best_row[i] = '0;
    sat_seen = 1'b0;
  endfunction

  // Sweep the row from high capacity to low for one item word and queue the
  // answer when the word closes a set.
  function automatic void knapsack_apply(input logic [zokdp_pkg::WEIGHT_W-1:0] weight,
                                         input logic [zokdp_pkg::VALUE_W-1:0] value,
                                         input logic last);
    logic [ACC_W:0] cand;
    int             idx;
    answer_t        ans;
    for (int j = MAX_CAP; j >= 1; j--) begin
      if (int'(weight) <= j) begin
        cand = {1'b0, best_row[j - int'(weight)]} + (ACC_W + 1)'(value);
        // An overflowing sum clamps to all ones and marks the set, win or lose.
        if (cand[ACC_W]) begin
          cand     = {1'b0, {ACC_W{1'b1}}};
          sat_seen = 1'b1;
        end
        if (cand[ACC_W-1:0] > best_row[j]) best_row[j] = cand[ACC_W-1:0];
      end
    end
    best_row[0] = '0;
    if (last) begin
      idx           = (int'(cap_reg) > MAX_CAP) ? MAX_CAP : int'(cap_reg);
      ans.saturated = sat_seen;
      if ((best_row[idx] >> zokdp_pkg::OUT_W) != 0) begin
        ans.best_value = '1;
        ans.saturated  = 1'b1;
      end else begin
        ans.best_value = zokdp_pkg::OUT_W'(best_row[idx]);
      end
      answer_q.push_back(ans);
      clear_row();
    end
  endfunction

  function automatic void note_mismatch(input string what, input longint want,
                                        input longint got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  function automatic logic [zokdp_pkg::WEIGHT_W-1:0] pick_weight(input int cap);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return zokdp_pkg::WEIGHT_W'($urandom_range(0, cap));
    else if (r < 70) return zokdp_pkg::WEIGHT_W'($urandom_range(0, 15));
    else return zokdp_pkg::WEIGHT_W'($urandom_range(0, 1023));
  endfunction

  function automatic logic [zokdp_pkg::VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    else if (r < 40) return zokdp_pkg::VALUE_W'($urandom_range(0, 255));
    else return zokdp_pkg::VALUE_W'($urandom_range(0, 65535));
  endfunction

  // Offer one item word and hold it until accepted. Starts and ends on a
  // falling edge; valid is low again when the task returns.
  task automatic send_word(input logic [zokdp_pkg::WEIGHT_W-1:0] weight,
                           input logic [zokdp_pkg::VALUE_W-1:0] value,
                           input logic last);
    while (!calm && $urandom_range(0, 99) < 32) @(negedge clk);
    in_valid       = 1'b1;
    in_item_weight = weight;
    in_item_value  = value;
    in_last_item   = last;
    do @(posedge clk); while (!in_ready);
    knapsack_apply(weight, value, last);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Wait for every answer, then for a full sweep so the engine is quiet.
  task automatic wait_idle();
    while (answer_q.size() != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [zokdp_pkg::CAP_W-1:0] cap);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = cap;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    cap_reg     = cap;
  endtask

  // Random sets of one to eight items at one capacity.
  task automatic run_random_sets(input logic [zokdp_pkg::CAP_W-1:0] cap, input int n_items);
    int sent;
    int set_len;
    sent = 0;
    write_capacity(cap);
    while (sent < n_items) begin
      set_len = $urandom_range(1, 8);
      for (int k = 0; k < set_len; k++) begin
        send_word(pick_weight(int'(cap)), pick_value(), k == set_len - 1);
      end
      sent += set_len;
    end
    wait_idle();
  endtask

  // Hand-picked sets: a textbook case, field extremes, zero capacity,
  // weights above capacity and zero weights.
  task automatic test_directed_sets();
    write_capacity(10'd10);
    send_word(10'd5, 16'd10, 1'b0);
    send_word(10'd4, 16'd40, 1'b0);
    send_word(10'd6, 16'd30, 1'b0);
    send_word(10'd3, 16'd50, 1'b1);
    wait_idle();
    write_capacity(10'd1023);
    send_word(10'd0, 16'hFFFF, 1'b0);
    send_word(10'd1023, 16'hFFFF, 1'b0);
    send_word(10'd512, 16'd0, 1'b1);
    wait_idle();
    write_capacity(10'd0);
    send_word(10'd0, 16'd500, 1'b0);
    send_word(10'd1, 16'd9, 1'b1);
    wait_idle();
    write_capacity(10'd5);
    send_word(10'd6, 16'd100, 1'b1);
    send_word(10'd1023, 16'd1, 1'b0);
    send_word(10'd5, 16'hFFFF, 1'b1);
    wait_idle();
    write_capacity(10'd1);
    send_word(10'd0, 16'd7, 1'b0);
    send_word(10'd1, 16'd3, 1'b1);
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while single-item sets keep
  // coming, so answers back up and the engine stops taking input.
  task automatic test_pressure_fill();
    write_capacity(10'd1023);
    hold_kick = 1'b1;
    for (int k = 0; k < 6; k++) send_word(pick_weight(63), pick_value(), 1'b1);
    wait_idle();
  endtask

  task automatic test_random_sets();
    run_random_sets(10'd1023, 75);
    run_random_sets(10'd0, 75);
    run_random_sets(zokdp_pkg::CAP_W'($urandom_range(1, 63)), 75);
    run_random_sets(zokdp_pkg::CAP_W'($urandom_range(0, 1023)), 75);
    run_random_sets(10'd1, 75);
    run_random_sets(zokdp_pkg::CAP_W'($urandom_range(512, 1023)), 75);
  endtask

  // Neither side idles here.
  task automatic test_calm_stream();
    calm = 1'b1;
    run_random_sets(10'd1023, 55);
    run_random_sets(zokdp_pkg::CAP_W'($urandom_range(0, 1023)), 55);
    calm = 1'b0;
  endtask

  // Receiver: random stalls, a counted hold-off on request, none when calm.
  always @(negedge clk) begin
    if (hold_kick) begin
      hold_kick = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else if (calm) begin
      out_ready = 1'b1;
    end else begin
      out_ready = ($urandom_range(0, 99) >= 32);
    end
  end

  // Compare each accepted answer word with the oldest expected one.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        note_mismatch("answer with none pending, best value", -1, longint'(out_best_value));
      end else begin
        want = answer_q.pop_front();
        if (out_best_value !== want.best_value)
          note_mismatch("best value", longint'(want.best_value), longint'(out_best_value));
        if (out_saturated !== want.saturated)
          note_mismatch("saturated flag", longint'(want.saturated), longint'(out_saturated));
      end
    end
  end

  // Watchdog on cycles with no word moving on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clear_row();
    cap_reg = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_sets();
    test_pressure_fill();
    test_random_sets();
    test_calm_stream();
    if (mismatch_count == 0 && answer_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== zero_one_knapsack_dp.f =====
+incdir+sv
sv/zokdp_pkg.sv
sv/zokdp_row_mem.sv
sv/zokdp_relax.sv
sv/zero_one_knapsack_dp.sv
sv/zero_one_knapsack_dp_chk.sv
dv/tb_top.sv
